@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the register allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define FNURA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define FNURA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

@@ src/fnura_pkg.sv @@
// ----------------------------------------------------------------------------
// fnura_pkg
// Types, constants and helpers shared by the register allocator modules.
// ----------------------------------------------------------------------------
package fnura_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int MAX_PHYS    = 32;
    localparam int NUM_VREGS   = 256;
    localparam int USE_SLOTS   = 1024;

    localparam int CLS_W      = 2;
    localparam int VREG_W     = 8;
    localparam int PREG_W     = 5;
    localparam int CNT_W      = 6;
    localparam int KEY_W      = CLS_W + VREG_W;
    localparam int PIDX_W     = CLS_W + PREG_W;
    localparam int SLOT_W     = 10;
    localparam int FILL_W     = SLOT_W + 1;
    localparam int CYC_W      = 16;
    localparam int TOT_W      = 16;
    localparam int RANK_W     = CYC_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [1:0] CMD_SCAN    = 2'd0;
    localparam logic [1:0] CMD_USE     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_DEF     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOPEND  = 2'd2;

    localparam logic [CNT_W-1:0]  RESET_COUNT = CNT_W'(16);
    localparam logic [TOT_W-1:0]  TOT_MAX     = '1;
    localparam logic [RANK_W-1:0] NO_USE_RANK = RANK_W'(1) << CYC_W;

    typedef struct packed {
        logic [1:0]        command;
        logic [CLS_W-1:0]  reg_class;
        logic [VREG_W-1:0] vreg;
        logic [CYC_W-1:0]  use_cycle;
    } t_request;

    typedef struct packed {
        logic [1:0]        status;
        logic [PREG_W-1:0] phys_reg;
        logic              load_added;
        logic              store_added;
        logic [VREG_W-1:0] spilled_vreg;
        logic              freed;
        logic [TOT_W-1:0]  load_total;
        logic [TOT_W-1:0]  store_total;
    } t_result;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
        logic              pending;
    } t_use_list;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_OWN, S_DEC, S_LINK, S_POP,
        S_VSEL, S_VLST, S_VCYC, S_VCMP, S_ASSIGN
    } t_state;

    typedef struct packed {
        t_state state;
        logic   accept;
        logic   finish;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] command;
        logic       clr_done;
        logic       pending;
        logic       last;
        logic       bound;
        logic       stack_empty;
        logic       cand_end;
        logic       cand_owned;
    } t_stat;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = CNT_W'(1);
        end else if (v > CFG_DATA_W'(MAX_PHYS)) begin
            c = CNT_W'(MAX_PHYS);
        end
        return c;
    endfunction

endpackage

@@ src/fnura_ram.sv @@
// ----------------------------------------------------------------------------
// fnura_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fnura_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fnura_ctrl.sv @@
// ----------------------------------------------------------------------------
// fnura_ctrl
// Sequencer for the allocator: steps each request through lookup, decision
// and, as needed, a list link, free-stack pop or victim walk and assignment.
// ----------------------------------------------------------------------------
module fnura_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fnura_pkg::t_stat i_stat,
    output fnura_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);

    fnura_pkg::t_state r_state;
    fnura_pkg::t_state n_state;
    logic              accept;
    logic              finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fnura_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        accept  = 1'b0;
        finish  = 1'b0;
        case (r_state)
            fnura_pkg::S_CLEAR: begin
                if (i_stat.clr_done) n_state = fnura_pkg::S_IDLE;
            end
            fnura_pkg::S_IDLE: begin
                if (i_start) begin
                    accept  = 1'b1;
                    n_state = fnura_pkg::S_LOOK;
                end
            end
            fnura_pkg::S_LOOK: n_state = fnura_pkg::S_OWN;
            fnura_pkg::S_OWN:  n_state = fnura_pkg::S_DEC;
            fnura_pkg::S_DEC: begin
                case (i_stat.command)
                    fnura_pkg::CMD_RELEASE: begin
                        if (i_stat.pending && !i_stat.last) begin
                            n_state = fnura_pkg::S_LINK;
                        end else begin
                            finish  = 1'b1;
                            n_state = fnura_pkg::S_IDLE;
                        end
                    end
                    fnura_pkg::CMD_USE, fnura_pkg::CMD_DEF: begin
                        if (i_stat.bound) begin
                            finish  = 1'b1;
                            n_state = fnura_pkg::S_IDLE;
                        end else if (!i_stat.stack_empty) begin
                            n_state = fnura_pkg::S_POP;
                        end else begin
                            n_state = fnura_pkg::S_VSEL;
                        end
                    end
                    default: begin
                        finish  = 1'b1;
                        n_state = fnura_pkg::S_IDLE;
                    end
                endcase
            end
            fnura_pkg::S_LINK: begin
                finish  = 1'b1;
                n_state = fnura_pkg::S_IDLE;
            end
            fnura_pkg::S_POP: n_state = fnura_pkg::S_ASSIGN;
            fnura_pkg::S_VSEL: begin
                if (i_stat.cand_end) begin
                    n_state = fnura_pkg::S_ASSIGN;
                end else if (i_stat.cand_owned) begin
                    n_state = fnura_pkg::S_VLST;
                end
            end
            fnura_pkg::S_VLST: n_state = fnura_pkg::S_VCYC;
            fnura_pkg::S_VCYC: n_state = fnura_pkg::S_VCMP;
            fnura_pkg::S_VCMP: n_state = fnura_pkg::S_VSEL;
            fnura_pkg::S_ASSIGN: begin
                finish  = 1'b1;
                n_state = fnura_pkg::S_IDLE;
            end
            default: n_state = fnura_pkg::S_IDLE;
        endcase
    end

    assign o_ctrl.state  = r_state;
    assign o_ctrl.accept = accept;
    assign o_ctrl.finish = finish;
    assign o_busy        = (r_state != fnura_pkg::S_IDLE);

endmodule

@@ src/fnura_dp.sv @@
// ----------------------------------------------------------------------------
// fnura_dp
// Allocator datapath: binding, owner, free-stack and use-list memories,
// per-class counts and valid bits, victim ranking and the result register.
// ----------------------------------------------------------------------------
module fnura_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fnura_pkg::t_ctrl                     i_ctrl,
    input  fnura_pkg::t_request                  i_request,
    input  logic                                 i_cfg_we,
    input  logic [fnura_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fnura_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output fnura_pkg::t_stat                     o_stat,
    output logic                                 o_done,
    output fnura_pkg::t_result                   o_result
);

    localparam int LIST_W = $bits(fnura_pkg::t_use_list);
    localparam int NPIDX  = fnura_pkg::NUM_CLASSES * fnura_pkg::MAX_PHYS;
    localparam int NKEY   = fnura_pkg::NUM_CLASSES * fnura_pkg::NUM_VREGS;

    // Control state.
    logic [fnura_pkg::CNT_W-1:0]  r_count [fnura_pkg::NUM_CLASSES];
    logic [fnura_pkg::CNT_W-1:0]  r_depth [fnura_pkg::NUM_CLASSES];
    logic [NPIDX-1:0]             r_owner_valid;
    logic [NPIDX-1:0]             r_stack_valid;
    logic [fnura_pkg::FILL_W-1:0] r_fill;
    logic [fnura_pkg::TOT_W-1:0]  r_load_tot;
    logic [fnura_pkg::TOT_W-1:0]  r_store_tot;
    logic [fnura_pkg::KEY_W:0]    r_clr;
    logic                         r_done;

    // Payload.
    fnura_pkg::t_request          r_req;
    fnura_pkg::t_use_list         r_list;
    logic [fnura_pkg::PREG_W-1:0] r_bind;
    logic [fnura_pkg::CNT_W-1:0]  r_i;
    logic                         r_found;
    logic [fnura_pkg::RANK_W-1:0] r_best;
    logic [fnura_pkg::PREG_W-1:0] r_r;
    logic [fnura_pkg::VREG_W-1:0] r_best_ov;
    logic [fnura_pkg::VREG_W-1:0] r_ov;
    logic                         r_vpend;
    logic                         r_spill;
    logic [1:0]                   r_status;
    logic [fnura_pkg::PREG_W-1:0] r_preg;
    logic                         r_load;
    logic                         r_store;
    logic [fnura_pkg::VREG_W-1:0] r_victim;
    logic                         r_freed;

    // Memory ports.
    logic                         list_we;
    logic [fnura_pkg::KEY_W-1:0]  list_waddr, list_raddr;
    fnura_pkg::t_use_list         list_wdata, list_q;
    logic [LIST_W-1:0]            list_q_raw;
    logic                         bind_we;
    logic [fnura_pkg::KEY_W-1:0]  bind_waddr;
    logic [fnura_pkg::PREG_W-1:0] bind_wdata;
    logic [fnura_pkg::PREG_W-1:0] bind_q;
    logic                         owner_we;
    logic [fnura_pkg::PIDX_W-1:0] owner_raddr;
    logic [fnura_pkg::VREG_W-1:0] owner_q;
    logic                         scan_we;
    logic                         link_we;
    logic [fnura_pkg::CYC_W-1:0]  cyc_q;
    logic [fnura_pkg::SLOT_W-1:0] link_q;
    logic                         stack_we;
    logic [fnura_pkg::PIDX_W-1:0] stack_raddr;
    logic [fnura_pkg::PREG_W-1:0] stack_q;

    // Decoded values.
    logic [fnura_pkg::CLS_W-1:0]  cls;
    logic [fnura_pkg::KEY_W-1:0]  key;
    logic [fnura_pkg::CNT_W-1:0]  cur_depth;
    logic [fnura_pkg::CNT_W-1:0]  cur_count;
    logic [fnura_pkg::PREG_W-1:0] dep_lo;
    logic [fnura_pkg::PREG_W-1:0] dep_m1;
    logic [fnura_pkg::RANK_W-1:0] rank;
    logic                         is_scan, is_rel, is_use, is_alloc;
    logic                         full, bound, stack_empty, cand_end, cand_owned;

    assign cls       = r_req.reg_class;
    assign key       = {r_req.reg_class, r_req.vreg};
    assign cur_depth = r_depth[cls];
    assign cur_count = r_count[cls];
    assign dep_lo    = cur_depth[fnura_pkg::PREG_W-1:0];
    assign dep_m1    = dep_lo - 1'b1;
    assign is_scan   = (r_req.command == fnura_pkg::CMD_SCAN);
    assign is_rel    = (r_req.command == fnura_pkg::CMD_RELEASE);
    assign is_use    = (r_req.command == fnura_pkg::CMD_USE);
    assign is_alloc  = is_use || (r_req.command == fnura_pkg::CMD_DEF);
    assign full      = (r_fill >= fnura_pkg::FILL_W'(fnura_pkg::USE_SLOTS));
    assign bound     = r_owner_valid[{cls, r_bind}] && (owner_q == r_req.vreg);
    assign stack_empty = (cur_depth == '0);
    assign cand_end  = (r_i == cur_count);
    assign cand_owned = r_owner_valid[{cls, r_i[fnura_pkg::PREG_W-1:0]}];
    assign rank      = r_vpend ? {1'b0, cyc_q} : fnura_pkg::NO_USE_RANK;
    assign list_q    = fnura_pkg::t_use_list'(list_q_raw);

    // Address and write selection.
    always_comb begin
        list_we    = 1'b0;
        list_waddr = key;
        list_wdata = r_list;
        list_raddr = key;
        owner_raddr = {cls, bind_q};
        bind_we    = 1'b0;
        bind_waddr = key;
        bind_wdata = r_r;
        owner_we   = 1'b0;
        scan_we    = 1'b0;
        link_we    = 1'b0;
        stack_we   = 1'b0;
        stack_raddr = {cls, dep_m1};
        case (i_ctrl.state)
            fnura_pkg::S_CLEAR: begin
                list_we    = !r_clr[fnura_pkg::KEY_W];
                list_waddr = r_clr[fnura_pkg::KEY_W-1:0];
                list_wdata = '0;
                bind_we    = !r_clr[fnura_pkg::KEY_W];
                bind_waddr = r_clr[fnura_pkg::KEY_W-1:0];
                bind_wdata = '0;
            end
            fnura_pkg::S_DEC: begin
                if (is_scan && !full) begin
                    list_we         = 1'b1;
                    list_wdata.head = r_list.pending ? r_list.head
                                                     : r_fill[fnura_pkg::SLOT_W-1:0];
                    list_wdata.tail = r_fill[fnura_pkg::SLOT_W-1:0];
                    list_wdata.pending = 1'b1;
                    scan_we         = 1'b1;
                    link_we         = r_list.pending;
                end
                if (is_rel && r_list.pending && (r_list.head == r_list.tail)) begin
                    list_we            = 1'b1;
                    list_wdata.pending = 1'b0;
                    stack_we = bound && (cur_depth < fnura_pkg::CNT_W'(fnura_pkg::MAX_PHYS));
                end
            end
            fnura_pkg::S_LINK: begin
                list_we         = 1'b1;
                list_wdata.head = link_q;
            end
            fnura_pkg::S_VSEL: owner_raddr = {cls, r_i[fnura_pkg::PREG_W-1:0]};
            fnura_pkg::S_VLST: list_raddr  = {cls, owner_q};
            fnura_pkg::S_ASSIGN: begin
                bind_we  = 1'b1;
                owner_we = 1'b1;
            end
            default: ;
        endcase
    end

    fnura_ram #(.WIDTH(LIST_W), .DEPTH(NKEY)) u_list_ram (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr),
        .i_wdata(list_wdata), .i_raddr(list_raddr), .o_rdata(list_q_raw)
    );

    fnura_ram #(.WIDTH(fnura_pkg::PREG_W), .DEPTH(NKEY)) u_bind_ram (
        .i_clk(i_clk), .i_we(bind_we), .i_waddr(bind_waddr),
        .i_wdata(bind_wdata), .i_raddr(key), .o_rdata(bind_q)
    );

    fnura_ram #(.WIDTH(fnura_pkg::VREG_W), .DEPTH(NPIDX)) u_owner_ram (
        .i_clk(i_clk), .i_we(owner_we), .i_waddr({cls, r_r}),
        .i_wdata(r_req.vreg), .i_raddr(owner_raddr), .o_rdata(owner_q)
    );

    fnura_ram #(.WIDTH(fnura_pkg::CYC_W), .DEPTH(fnura_pkg::USE_SLOTS)) u_cyc_ram (
        .i_clk(i_clk), .i_we(scan_we), .i_waddr(r_fill[fnura_pkg::SLOT_W-1:0]),
        .i_wdata(r_req.use_cycle), .i_raddr(list_q.head), .o_rdata(cyc_q)
    );

    fnura_ram #(.WIDTH(fnura_pkg::SLOT_W), .DEPTH(fnura_pkg::USE_SLOTS)) u_link_ram (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(r_list.tail),
        .i_wdata(r_fill[fnura_pkg::SLOT_W-1:0]), .i_raddr(r_list.head), .o_rdata(link_q)
    );

    fnura_ram #(.WIDTH(fnura_pkg::PREG_W), .DEPTH(NPIDX)) u_stack_ram (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr({cls, dep_lo}),
        .i_wdata(r_bind), .i_raddr(stack_raddr), .o_rdata(stack_q)
    );

    // Control state: counts, stack depths, valid bits and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < fnura_pkg::NUM_CLASSES; c++) begin
                r_count[c] <= fnura_pkg::RESET_COUNT;
                r_depth[c] <= fnura_pkg::RESET_COUNT;
            end
            r_owner_valid <= '0;
            r_stack_valid <= '0;
            r_fill        <= '0;
            r_load_tot    <= '0;
            r_store_tot   <= '0;
            r_clr         <= '0;
            r_done        <= 1'b0;
        end else begin
            r_done <= i_ctrl.finish;
            case (i_ctrl.state)
                fnura_pkg::S_CLEAR: begin
                    if (!r_clr[fnura_pkg::KEY_W]) r_clr <= r_clr + 1'b1;
                end
                fnura_pkg::S_DEC: begin
                    if (is_scan && !full) r_fill <= r_fill + 1'b1;
                    if (is_alloc && !bound) begin
                        if (is_use && (r_load_tot != fnura_pkg::TOT_MAX)) begin
                            r_load_tot <= r_load_tot + 1'b1;
                        end
                        if (!stack_empty) r_depth[cls] <= cur_depth - 1'b1;
                    end
                    if (is_rel && r_list.pending && (r_list.head == r_list.tail)
                            && bound) begin
                        r_owner_valid[{cls, r_bind}] <= 1'b0;
                        if (cur_depth < fnura_pkg::CNT_W'(fnura_pkg::MAX_PHYS)) begin
                            r_stack_valid[{cls, dep_lo}] <= 1'b1;
                            r_depth[cls] <= cur_depth + 1'b1;
                        end
                    end
                end
                fnura_pkg::S_ASSIGN: begin
                    r_owner_valid[{cls, r_r}] <= 1'b1;
                    if (r_spill && (r_store_tot != fnura_pkg::TOT_MAX)) begin
                        r_store_tot <= r_store_tot + 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_cfg_we) begin
                r_count[i_cfg_idx] <= fnura_pkg::clamp_count(i_cfg_wdata);
                r_depth[i_cfg_idx] <= fnura_pkg::clamp_count(i_cfg_wdata);
                r_owner_valid[{i_cfg_idx, {fnura_pkg::PREG_W{1'b0}}} +: fnura_pkg::MAX_PHYS]
                    <= '0;
                r_stack_valid[{i_cfg_idx, {fnura_pkg::PREG_W{1'b0}}} +: fnura_pkg::MAX_PHYS]
                    <= '0;
            end
        end
    end

    // Request payload, victim walk and result fields.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_req    <= i_request;
            r_status <= fnura_pkg::ST_OK;
            r_preg   <= '0;
            r_load   <= 1'b0;
            r_store  <= 1'b0;
            r_victim <= '0;
            r_freed  <= 1'b0;
            r_spill  <= 1'b0;
        end
        case (i_ctrl.state)
            fnura_pkg::S_OWN: begin
                r_list <= list_q;
                r_bind <= bind_q;
            end
            fnura_pkg::S_DEC: begin
                if (is_scan && full) r_status <= fnura_pkg::ST_FULL;
                if (is_rel) begin
                    if (!r_list.pending) begin
                        r_status <= fnura_pkg::ST_NOPEND;
                    end else if ((r_list.head == r_list.tail) && bound) begin
                        r_preg  <= r_bind;
                        r_freed <= 1'b1;
                    end
                end
                if (is_alloc) begin
                    if (bound) begin
                        r_preg <= r_bind;
                    end else begin
                        r_load <= is_use;
                        if (stack_empty) begin
                            r_spill <= 1'b1;
                            r_i     <= '0;
                            r_found <= 1'b0;
                            r_best  <= '0;
                            r_r     <= '0;
                        end
                    end
                end
            end
            fnura_pkg::S_POP: begin
                // Entries never pushed since reset or reconfiguration hold their index.
                r_r <= r_stack_valid[{cls, dep_lo}] ? stack_q : dep_lo;
            end
            fnura_pkg::S_VSEL: begin
                if (!cand_end && !cand_owned) r_i <= r_i + 1'b1;
            end
            fnura_pkg::S_VLST: r_ov    <= owner_q;
            fnura_pkg::S_VCYC: r_vpend <= list_q.pending;
            fnura_pkg::S_VCMP: begin
                if (!r_found || (rank > r_best)) begin
                    r_found   <= 1'b1;
                    r_best    <= rank;
                    r_r       <= r_i[fnura_pkg::PREG_W-1:0];
                    r_best_ov <= r_ov;
                end
                r_i <= r_i + 1'b1;
            end
            fnura_pkg::S_ASSIGN: begin
                r_preg   <= r_r;
                r_store  <= r_spill;
                r_victim <= (r_spill && r_found) ? r_best_ov : '0;
            end
            default: ;
        endcase
    end

    assign o_stat.command     = r_req.command;
    assign o_stat.clr_done    = r_clr[fnura_pkg::KEY_W];
    assign o_stat.pending     = r_list.pending;
    assign o_stat.last        = (r_list.head == r_list.tail);
    assign o_stat.bound       = bound;
    assign o_stat.stack_empty = stack_empty;
    assign o_stat.cand_end    = cand_end;
    assign o_stat.cand_owned  = cand_owned;

    assign o_done                = r_done;
    assign o_result.status       = r_status;
    assign o_result.phys_reg     = r_preg;
    assign o_result.load_added   = r_load;
    assign o_result.store_added  = r_store;
    assign o_result.spilled_vreg = r_victim;
    assign o_result.freed        = r_freed;
    assign o_result.load_total   = r_load_tot;
    assign o_result.store_total  = r_store_tot;

endmodule

@@ src/furthest_next_use_reg_alloc_top.sv @@
// ----------------------------------------------------------------------------
// furthest_next_use_reg_alloc_top
// Local register allocator with furthest-next-use spilling, one allocator
// shared by all register classes, each with its own count and free stack.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low, and exactly one
// result follows, shown for a single cycle with o_done high; the receiver
// cannot hold it off, so it must capture the result in that cycle. After
// reset the block stays busy while it empties every use list and clears
// the binding table, one entry of each per cycle. A scan, a release and an
// allocation that finds the operand already bound each pass through the
// lookup, owner and decision states before the result strobe; a release
// that moves to the next pending use adds a link state, and an allocation
// served from the free stack adds a pop state and an assign state. When the
// free stack of the class is empty, the victim search walks the physical
// registers of the class one by one, and each register that holds a value
// needs three chained memory reads (owner, use list, cycle of the next use)
// before it is ranked. Writing a class count reinitialises that class at
// once and may be done whenever busy is low; recorded uses and the running
// totals are kept.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module furthest_next_use_reg_alloc_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fnura_pkg::t_request              i_request,
    output logic                             o_done,
    output fnura_pkg::t_result               o_result,
    input  logic                             i_cfg_we,
    input  logic [fnura_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fnura_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // The sequencer and the datapath talk only through these two groups.
    fnura_pkg::t_ctrl ctrl;
    fnura_pkg::t_stat stat;

    fnura_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    fnura_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // A result only ever follows a cycle of work on a request.
    `FNURA_ASSERT_IMP(a_done_after_work, i_clk, i_rst_n, o_done, $past(busy))
    // An accepted request keeps the block busy in the following cycle.
    `FNURA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // A victim is reported only alongside a spill store.
    `FNURA_ASSERT_IMP(a_victim_with_store, i_clk, i_rst_n,
        o_done && !o_result.store_added, o_result.spilled_vreg == '0)
    // Freeing a register and allocating one never happen in the same request.
    `FNURA_ASSERT_IMP(a_free_not_alloc, i_clk, i_rst_n, o_done && o_result.freed,
        !o_result.load_added && !o_result.store_added)

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Register allocator testbench
// Drives scan, use, release and def requests into the furthest-next-use
// allocator, predicts every result with a cycle-free model held here and
// checks each strobed result field by field, across several class-size
// settings with random gaps between requests.
// ----------------------------------------------------------------------------
module testbench;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    fnura_pkg::t_request i_request = '0;
    logic o_done;
    fnura_pkg::t_result o_result;
    logic i_cfg_we = 1'b0;
    logic [fnura_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [fnura_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    furthest_next_use_reg_alloc_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_request  (i_request),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The run is cut off here if the block hangs; the slowest correct run is
    // far shorter than this.
    initial begin
        #20000000;
        $display("testbench: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Allocator shadow state. Keys are class * 256 + vreg for the binding and
    // use lists, and class * 32 + register for the owner table and stacks.
    // ------------------------------------------------------------------------
    int          class_size [fnura_pkg::NUM_CLASSES];
    bit          is_bound   [fnura_pkg::NUM_CLASSES*fnura_pkg::NUM_VREGS];
    bit [4:0]    bound_reg  [fnura_pkg::NUM_CLASSES*fnura_pkg::NUM_VREGS];
    bit          is_owned   [fnura_pkg::NUM_CLASSES*fnura_pkg::MAX_PHYS];
    bit [7:0]    owner_vreg [fnura_pkg::NUM_CLASSES*fnura_pkg::MAX_PHYS];
    bit [4:0]    free_regs  [fnura_pkg::NUM_CLASSES*fnura_pkg::MAX_PHYS];
    int          free_depth [fnura_pkg::NUM_CLASSES];
    bit [15:0]   slot_cycle [fnura_pkg::USE_SLOTS];
    int          slot_next  [fnura_pkg::USE_SLOTS];
    int          list_head  [fnura_pkg::NUM_CLASSES*fnura_pkg::NUM_VREGS];
    int          list_tail  [fnura_pkg::NUM_CLASSES*fnura_pkg::NUM_VREGS];
    bit          has_uses   [fnura_pkg::NUM_CLASSES*fnura_pkg::NUM_VREGS];
    int          slots_used;
    bit [15:0]   reloads;
    bit [15:0]   spills;

    fnura_pkg::t_request pending_reqs [$];
    fnura_pkg::t_result  expected_results [$];
    int          mismatches = 0;
    int          idle_left = 0;

    // Refills the free stack of one class and forgets every binding in it.
    function automatic void reset_class(int c);
        for (int i = 0; i < fnura_pkg::MAX_PHYS; i++) begin
            is_owned[c*fnura_pkg::MAX_PHYS+i] = 1'b0;
            owner_vreg[c*fnura_pkg::MAX_PHYS+i] = '0;
            free_regs[c*fnura_pkg::MAX_PHYS+i] = 5'(i);
        end
        free_depth[c] = class_size[c];
        for (int i = 0; i < fnura_pkg::NUM_VREGS; i++) begin
            is_bound[c*fnura_pkg::NUM_VREGS+i] = 1'b0;
            bound_reg[c*fnura_pkg::NUM_VREGS+i] = '0;
        end
    endfunction

    function automatic void set_class_size(int c, int value);
        int n;
        n = value;
        if (n < 1) n = 1;
        if (n > fnura_pkg::MAX_PHYS) n = fnura_pkg::MAX_PHYS;
        class_size[c] = n;
        reset_class(c);
    endfunction

    // Takes a register off the free stack, or evicts the holder whose next
    // use lies furthest ahead (no pending use ranks above every cycle).
    function automatic bit [4:0] take_register(int c, int v, output bit spilled,
                                               output bit [7:0] victim);
        int base;
        int r;
        int key;
        bit found;
        bit [16:0] best;
        bit [16:0] rank;
        base = c * fnura_pkg::MAX_PHYS;
        r = 0;
        found = 1'b0;
        best = '0;
        spilled = 1'b0;
        victim = '0;
        if (free_depth[c] > 0) begin
            free_depth[c]--;
            r = free_regs[base+free_depth[c]];
        end else begin
            for (int i = 0; i < class_size[c]; i++) begin
                if (is_owned[base+i]) begin
                    key = c * fnura_pkg::NUM_VREGS + owner_vreg[base+i];
                    rank = has_uses[key] ? {1'b0, slot_cycle[list_head[key]]} : 17'h10000;
                    if (!found || rank > best) begin
                        found = 1'b1;
                        best = rank;
                        r = i;
                    end
                end
            end
            if (is_owned[base+r]) begin
                is_bound[c*fnura_pkg::NUM_VREGS+owner_vreg[base+r]] = 1'b0;
                victim = owner_vreg[base+r];
            end
            spilled = 1'b1;
            if (spills != 16'hFFFF) spills++;
        end
        is_owned[base+r] = 1'b1;
        owner_vreg[base+r] = 8'(v);
        is_bound[c*fnura_pkg::NUM_VREGS+v] = 1'b1;
        bound_reg[c*fnura_pkg::NUM_VREGS+v] = 5'(r);
        return 5'(r);
    endfunction

    // Works out the result of one accepted request and updates the shadow.
    function automatic fnura_pkg::t_result allocate_expect(fnura_pkg::t_request q);
        fnura_pkg::t_result res;
        int c;
        int v;
        int key;
        int s;
        bit sp;
        bit [7:0] vic;
        res = '0;
        c = q.reg_class;
        v = q.vreg;
        key = c * fnura_pkg::NUM_VREGS + v;
        sp = 1'b0;
        vic = '0;
        case (q.command)
            fnura_pkg::CMD_SCAN: begin
                if (slots_used >= fnura_pkg::USE_SLOTS) begin
                    res.status = fnura_pkg::ST_FULL;
                end else begin
                    s = slots_used;
                    slots_used++;
                    slot_cycle[s] = q.use_cycle;
                    if (has_uses[key]) begin
                        slot_next[list_tail[key]] = s;
                    end else begin
                        list_head[key] = s;
                        has_uses[key] = 1'b1;
                    end
                    list_tail[key] = s;
                end
            end
            fnura_pkg::CMD_USE: begin
                if (is_bound[key]) begin
                    res.phys_reg = bound_reg[key];
                end else begin
                    res.load_added = 1'b1;
                    if (reloads != 16'hFFFF) reloads++;
                    res.phys_reg = take_register(c, v, sp, vic);
                end
            end
            fnura_pkg::CMD_RELEASE: begin
                if (!has_uses[key]) begin
                    res.status = fnura_pkg::ST_NOPEND;
                end else begin
                    if (list_head[key] == list_tail[key]) has_uses[key] = 1'b0;
                    else list_head[key] = slot_next[list_head[key]];
                    if (!has_uses[key] && is_bound[key]) begin
                        is_bound[key] = 1'b0;
                        is_owned[c*fnura_pkg::MAX_PHYS+bound_reg[key]] = 1'b0;
                        if (free_depth[c] < fnura_pkg::MAX_PHYS) begin
                            free_regs[c*fnura_pkg::MAX_PHYS+free_depth[c]] = bound_reg[key];
                            free_depth[c]++;
                        end
                        res.phys_reg = bound_reg[key];
                        res.freed = 1'b1;
                    end
                end
            end
            default: begin
                if (is_bound[key]) res.phys_reg = bound_reg[key];
                else res.phys_reg = take_register(c, v, sp, vic);
            end
        endcase
        res.store_added = sp;
        res.spilled_vreg = sp ? vic : 8'd0;
        res.load_total = reloads;
        res.store_total = spills;
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A request is taken at an edge where start is high and busy is
    // low; the prediction is made there so the shadow advances in the same
    // order as the block. Start is assigned once per edge on every path.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) begin
                expected_results.insert(expected_results.size(),
                                        allocate_expect(i_request));
                idle_left = pick_gap();
            end
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_request <= pending_reqs.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result strobe is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        fnura_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status
                        || o_result.phys_reg !== want.phys_reg
                        || o_result.load_added !== want.load_added
                        || o_result.store_added !== want.store_added
                        || o_result.spilled_vreg !== want.spilled_vreg
                        || o_result.freed !== want.freed
                        || o_result.load_total !== want.load_total
                        || o_result.store_total !== want.store_total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------------
    function automatic void queue_request(bit [1:0] cmd, int c, int v, int cyc);
        fnura_pkg::t_request q;
        q.command = cmd;
        q.reg_class = 2'(c);
        q.vreg = 8'(v);
        q.use_cycle = 16'(cyc);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    // Waits until every request is taken and every result has come back,
    // then lets the block settle back to idle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || idle_left != 0
               || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_sizes(int s0, int s1, int s2, int s3);
        int sizes [4];
        sizes = '{s0, s1, s2, s3};
        for (int i = 0; i < fnura_pkg::NUM_CLASSES; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= fnura_pkg::CFG_IDX_W'(i);
            i_cfg_wdata <= fnura_pkg::CFG_DATA_W'(sizes[i]);
            set_class_size(i, sizes[i] & 63);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A well-formed block: scan the uses of a few vregs in schedule order,
    // then walk the same uses: an optional def, a use, and often a release.
    // Noise items are random requests of any kind.
    task automatic queue_random(int budget);
        int produced;
        int c;
        int nv;
        int ninstr;
        int cyc;
        int pool [8];
        int order [$];
        produced = 0;
        while (produced < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                c = $urandom_range(0, fnura_pkg::NUM_CLASSES - 1);
                nv = $urandom_range(2, 8);
                for (int i = 0; i < nv; i++)
                    pool[i] = $urandom_range(0, fnura_pkg::NUM_VREGS - 1);
                ninstr = $urandom_range(2, 7);
                cyc = $urandom_range(0, 65535);
                order.delete();
                for (int i = 0; i < ninstr; i++) begin
                    order.insert(order.size(), pool[$urandom_range(0, nv - 1)]);
                    queue_request(fnura_pkg::CMD_SCAN, c, order[i], cyc);
                    cyc = cyc + $urandom_range(0, 9);
                end
                foreach (order[i]) begin
                    if ($urandom_range(0, 4) == 0) begin
                        queue_request(fnura_pkg::CMD_DEF, c, order[i], 0);
                        produced++;
                    end
                    queue_request(fnura_pkg::CMD_USE, c, order[i], 0);
                    if ($urandom_range(0, 9) != 0) begin
                        queue_request(fnura_pkg::CMD_RELEASE, c, order[i], 0);
                        produced++;
                    end
                end
                produced += 2 * ninstr;
            end else begin
                queue_request(2'($urandom_range(0, 3)), $urandom_range(0, 3),
                              $urandom_range(0, 255), $urandom_range(0, 65535));
                produced++;
            end
        end
    endtask

    initial begin
        set_class_size(0, 16);
        set_class_size(1, 16);
        set_class_size(2, 16);
        set_class_size(3, 16);
        foreach (has_uses[i]) has_uses[i] = 1'b0;
        slots_used = 0;
        reloads = '0;
        spills = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset sizes: field extremes, a use that is
        // already bound, a def of a held vreg, a release with nothing pending,
        // a use never scanned, and a release that is not the last use.
        queue_request(fnura_pkg::CMD_SCAN, 0, 0, 0);
        queue_request(fnura_pkg::CMD_SCAN, 0, 255, 65535);
        queue_request(fnura_pkg::CMD_SCAN, 3, 170, 16'h5555);
        queue_request(fnura_pkg::CMD_USE, 0, 0, 0);
        queue_request(fnura_pkg::CMD_USE, 0, 0, 65535);
        queue_request(fnura_pkg::CMD_DEF, 0, 255, 0);
        queue_request(fnura_pkg::CMD_DEF, 0, 255, 0);
        queue_request(fnura_pkg::CMD_RELEASE, 0, 0, 0);
        queue_request(fnura_pkg::CMD_RELEASE, 0, 0, 0);
        queue_request(fnura_pkg::CMD_USE, 1, 5, 16'hAAAA);
        queue_request(fnura_pkg::CMD_RELEASE, 0, 255, 0);
        queue_request(fnura_pkg::CMD_USE, 3, 170, 0);
        queue_request(fnura_pkg::CMD_RELEASE, 3, 170, 0);
        queue_request(fnura_pkg::CMD_SCAN, 2, 1, 10);
        queue_request(fnura_pkg::CMD_SCAN, 2, 1, 20);
        queue_request(fnura_pkg::CMD_USE, 2, 1, 0);
        queue_request(fnura_pkg::CMD_RELEASE, 2, 1, 0);
        queue_request(fnura_pkg::CMD_RELEASE, 2, 1, 0);
        queue_request(fnura_pkg::CMD_RELEASE, 1, 5, 0);
        drain();

        // Single-register classes spill whenever their one register is held.
        write_sizes(1, 32, 0, 63);
        queue_request(fnura_pkg::CMD_DEF, 0, 7, 0);
        queue_request(fnura_pkg::CMD_DEF, 0, 8, 0);
        queue_request(fnura_pkg::CMD_USE, 2, 9, 0);
        queue_request(fnura_pkg::CMD_USE, 2, 10, 0);
        queue_random(120);
        drain();

        write_sizes(2, 3, 1, 4);
        queue_random(150);
        drain();

        write_sizes(63, 5, 32, 2);
        queue_random(130);
        drain();

        write_sizes($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom_range(0, 63));
        queue_random(140);
        drain();

        // Small classes against the lists left over from earlier phases.
        write_sizes(3, 1, 2, 4);
        queue_random(80);
        drain();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/fnura_pkg.sv
src/fnura_ram.sv
src/fnura_ctrl.sv
src/fnura_dp.sv
src/furthest_next_use_reg_alloc_top.sv
sim/testbench.sv
